// ===== design/lrk_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU-K replacer package
// Action and status codes, pool size, and the controller/datapath command group.
// ----------------------------------------------------------------------------
package lrk_pkg;

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_SET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_EVICT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_VICTIM = 2'd1,
        ST_RANGE     = 2'd2,
        ST_PINNED    = 2'd3
    } status_t;

    localparam int STAMP_W = 32;

    // buffer pool size, fixed by the 6-bit frame fields on both streams
    localparam int POOL_FRAMES = 64;

    // command from controller to datapath
    typedef struct packed {
        logic load;       // capture request, read per-frame state
        logic exec;       // perform record/set/remove
        logic scan_start; // clear scan row valid
        logic scan_step;  // compare one frame
        logic victim;     // untrack best frame or flag no victim
    } lrk_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
    } lrk_sts_t;

endpackage

// ===== design/lrk_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU-K replacer controller
// Sequences one request at a time: load, execute or scan, then present.
// ----------------------------------------------------------------------------
module lrk_ctrl
    import lrk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     is_evict,
    input  logic     out_free,
    input  lrk_sts_t sts,
    output logic     in_ready,
    output logic     res_load,
    output lrk_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_VICT = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = is_evict;
                    state_next     = is_evict ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_PUT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_VICT;
            end
            S_VICT:
            begin
                cmd.victim = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                // wait for the output register to be free
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/lrk_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU-K replacer datapath
// Per-frame flags in flops, counts and stamps in a memory, serial evict scan.
// ----------------------------------------------------------------------------
module lrk_datapath
    import lrk_pkg::*;
#(
    parameter int MAX_K = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lrk_cmd_t                         cmd,
    output lrk_sts_t                         sts,
    input  logic [2:0]                       history_depth,
    input  logic [1:0]                       req_action,
    input  logic [5:0]                       req_frame,
    input  logic                             req_ev,
    output logic [1:0]                       res_status,
    output logic [5:0]                       res_victim,
    output logic [$clog2(POOL_FRAMES+1)-1:0] res_count
);

    localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int TW = $clog2(POOL_FRAMES + 1);
    localparam int SW = MAX_K * STAMP_W;
    localparam int RW = CW + SW;

    logic [POOL_FRAMES-1:0] tracked_reg;
    logic [POOL_FRAMES-1:0] evict_reg;
    logic [TW-1:0]          total_reg;
    logic [STAMP_W-1:0]     gstamp_reg;

    // one row per frame: access count on top, then MAX_K stamps, newest in slot 0
    logic [RW-1:0] stamp_mem [POOL_FRAMES];
    logic [RW-1:0] row_reg;
    logic [CW-1:0] row_cnt;
    logic [SW-1:0] row_stamps;
    logic [CW-1:0] rec_cnt;
    logic [SW-1:0] rec_stamps;

    logic [1:0]         act_reg;
    logic [FW-1:0]      frame_reg;
    logic               range_bad_reg;
    logic               ev_reg;
    logic [1:0]         status_reg;
    logic [FW-1:0]      victim_reg;

    logic [FW-1:0]      scan_reg;
    logic               scan_vld_reg;     // row_reg holds frame scan_reg - 1
    logic [FW-1:0]      cand_reg;
    logic               found_reg;
    logic               best_young_reg;
    logic [STAMP_W-1:0] best_key_reg;
    logic [FW-1:0]      best_f_reg;

    logic [CW-1:0]      k_eff;
    logic [FW-1:0]      mem_addr;

    always_comb
    begin
        if (history_depth == 3'd0)
            k_eff = CW'(1);
        else if (32'(history_depth) > MAX_K)
            k_eff = CW'(MAX_K);
        else
            k_eff = CW'(history_depth);
    end

    assign mem_addr   = cmd.load ? FW'(req_frame) : scan_reg;
    assign row_cnt    = row_reg[SW +: CW];
    assign row_stamps = row_reg[SW-1:0];

    // new row for a record: shift the history, saturate the count at K
    always_comb
    begin
        rec_stamps                = row_stamps << STAMP_W;
        rec_stamps[STAMP_W-1:0]   = gstamp_reg + 1'b1;
        if (!tracked_reg[frame_reg])
            rec_cnt = CW'(1);
        else if (row_cnt >= k_eff)
            rec_cnt = k_eff;
        else
            rec_cnt = row_cnt + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        row_reg <= stamp_mem[mem_addr];
        if (cmd.exec && !range_bad_reg && act_reg == ACT_RECORD)
            stamp_mem[frame_reg] <= {rec_cnt, rec_stamps};
    end

    // candidate evaluation for the row read in the previous cycle
    logic [CW-1:0]      c_cnt;
    logic [CW-1:0]      c_use;
    logic               c_young;
    logic [KW-1:0]      c_slot;
    logic [STAMP_W-1:0] c_key;
    logic               c_ok;
    logic               c_win;

    always_comb
    begin
        c_cnt   = row_cnt;
        c_use   = (c_cnt == '0) ? CW'(1) : c_cnt;
        c_young = c_use < k_eff;
        c_slot  = c_young ? KW'(c_use - 1'b1) : KW'(k_eff - 1'b1);
        c_key   = row_stamps[c_slot*STAMP_W +: STAMP_W];
        c_ok    = scan_vld_reg && tracked_reg[cand_reg] && evict_reg[cand_reg];
        c_win   = c_ok && (!found_reg || (c_young && !best_young_reg) ||
                  (c_young == best_young_reg && c_key < best_key_reg));
    end

    assign sts.scan_last = scan_vld_reg && (cand_reg == FW'(POOL_FRAMES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg  <= '0;
            evict_reg    <= '0;
            total_reg    <= '0;
            gstamp_reg   <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
                scan_vld_reg <= 1'b0;
            else if (cmd.scan_step)
                scan_vld_reg <= 1'b1;
            if (cmd.exec && !range_bad_reg)
            begin
                unique case (act_reg)
                    ACT_RECORD:
                    begin
                        gstamp_reg <= gstamp_reg + 1'b1;
                        if (!tracked_reg[frame_reg])
                        begin
                            tracked_reg[frame_reg] <= 1'b1;
                            evict_reg[frame_reg]   <= 1'b1;
                            total_reg              <= total_reg + 1'b1;
                        end
                    end
                    ACT_SET:
                    begin
                        if (tracked_reg[frame_reg] && evict_reg[frame_reg] != ev_reg)
                        begin
                            evict_reg[frame_reg] <= ev_reg;
                            total_reg <= ev_reg ? total_reg + 1'b1 : total_reg - 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (tracked_reg[frame_reg] && evict_reg[frame_reg])
                        begin
                            tracked_reg[frame_reg] <= 1'b0;
                            evict_reg[frame_reg]   <= 1'b0;
                            total_reg              <= total_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.victim && found_reg)
            begin
                tracked_reg[best_f_reg] <= 1'b0;
                evict_reg[best_f_reg]   <= 1'b0;
                total_reg               <= total_reg - 1'b1;
            end
        end
    end

    // request capture, scan bookkeeping and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg       <= req_action;
            frame_reg     <= FW'(req_frame);
            range_bad_reg <= (32'(req_frame) >= POOL_FRAMES);
            ev_reg        <= req_ev;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            status_reg    <= ST_OK;
            victim_reg    <= '0;
        end
        if (cmd.scan_step)
        begin
            cand_reg <= scan_reg;
            scan_reg <= scan_reg + 1'b1;
            if (c_win)
            begin
                found_reg      <= 1'b1;
                best_young_reg <= c_young;
                best_key_reg   <= c_key;
                best_f_reg     <= cand_reg;
            end
        end
        if (cmd.exec)
        begin
            if (range_bad_reg)
                status_reg <= ST_RANGE;
            else if (act_reg == ACT_REMOVE && tracked_reg[frame_reg] && !evict_reg[frame_reg])
                status_reg <= ST_PINNED;
        end
        if (cmd.victim)
        begin
            if (found_reg)
                victim_reg <= best_f_reg;
            else
                status_reg <= ST_NO_VICTIM;
        end
    end

    assign res_status = status_reg;
    assign res_victim = 6'(victim_reg);
    assign res_count  = total_reg;

endmodule

// ===== design/lru_k_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Victim selector for a buffer pool; one result transfer per request.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis: one request per transfer. tdata = {evictable_value, frame_index,
//  action}, action at bit 0. m_axis: one result per request, tdata =
//  {evictable_count, victim_frame, status}, status at bit 0.
//  history_depth is written through cfg_we/cfg_wdata; the user must write it
//  only while the block is idle, which the block itself does not enforce.
//  Timing: requests are taken one at a time. Record, set and remove are
//  loaded, executed, then placed in the output register; evict is loaded,
//  then runs the serial scan, which reads one stamp row and compares one
//  frame per cycle, then the victim step, then the result is placed.
//  A new request is accepted once the previous result has been loaded into
//  the output register, so it may still be waiting on the receiver.
//  Reset clears the frame flags, the global stamp and the evictable total.
//  The count and stamp memory is not cleared; a row counts only while its
//  frame is tracked, and a record writes it before it is ranked.
//  When the receiver stalls, the result is held in the output register and
//  the block holds its next result until the register frees.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer
    import lrk_pkg::*;
#(
    parameter int MAX_K = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action[1:0], frame_index[7:2], evictable_value[8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // status[1:0], victim_frame[7:2], evictable_count[14:8]
);

    localparam int TW = $clog2(POOL_FRAMES + 1);

    logic [2:0]    hd_reg;
    lrk_cmd_t      cmd;
    lrk_sts_t      sts;
    logic          in_ready;
    logic          res_load;
    logic          in_fire;
    logic [1:0]    res_status;
    logic [5:0]    res_victim;
    logic [TW-1:0] res_count;
    logic          ovld_reg;
    logic [15:0]   odata_reg;

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    // configuration register: K
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hd_reg <= 3'd2;
        else if (cfg_we)
            hd_reg <= cfg_wdata;
    end

    lrk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .is_evict (s_axis_tdata[1:0] == ACT_EVICT),
        .out_free (!ovld_reg || m_axis_tready),
        .sts      (sts),
        .in_ready (in_ready),
        .res_load (res_load),
        .cmd      (cmd)
    );

    lrk_datapath #(
        .MAX_K (MAX_K)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .history_depth (hd_reg),
        .req_action    (s_axis_tdata[1:0]),
        .req_frame     (s_axis_tdata[7:2]),
        .req_ev        (s_axis_tdata[8]),
        .res_status    (res_status),
        .res_victim    (res_victim),
        .res_count     (res_count)
    );

    // output register: hold result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (res_load)
            ovld_reg <= 1'b1;
        else if (m_axis_tready)
            ovld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            odata_reg <= {1'b0, 7'(res_count), res_victim, res_status};
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

// ===== design/lru_k_frame_replacer_checker.sv =====
// ----------------------------------------------------------------------------
// LRU-K frame replacer checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // request accept is not followed by another in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // count never exceeds the frame total
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:8] <= 7'd64)
        else $error("evictable count out of range");

    // no victim, range and pinned errors report frame zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[7:2] == 6'd0)
        else $error("victim on error");

endmodule

bind lru_k_frame_replacer lru_k_frame_replacer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/lru_k_frame_replacer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU-K frame replacer testbench
// Drives requests into the replacer and checks each result transfer against
// a local LRU-K predictor. Runs directed cases, then random ones, at several
// history depths, with random stalls on both sides in all but the last run.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_tb;
    import lrk_pkg::*;

    localparam int NFR    = 64;
    localparam int KMAX   = 4;
    localparam int LIMIT  = 2000000;

    // laid out as on m_axis_tdata, first field highest
    typedef struct packed {
        logic [6:0] ev_count;
        logic [5:0] victim;
        status_t    status;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    // Predictor state
    logic [2:0]  depth_reg;
    logic        trk [NFR];
    logic        evm [NFR];
    int unsigned acnt [NFR];
    logic [31:0] stamps [NFR][KMAX];
    logic [31:0] gstamp;
    logic [6:0]  ev_total;

    result_t     expected_q [$];
    int          errors;
    int          cycles;
    int          n_sent;
    int          n_checked;
    bit          stall_en;

    lru_k_frame_replacer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // action, frame_index, evictable_value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // status, victim_frame, evictable_count
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Global watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Work out the result of one request and advance the predictor state
    function automatic result_t predict_lru_k(action_t act, logic [5:0] f, logic ev);
        result_t     r;
        int unsigned k;
        int unsigned c;
        int          best_f;
        bit          found;
        bit          best_young;
        bit          young;
        logic [31:0] best_key;
        logic [31:0] key;
        k = (depth_reg == 0) ? 1 : ((depth_reg > KMAX) ? KMAX : depth_reg);
        r.status = ST_OK;
        r.victim = '0;
        found = 1'b0;
        best_young = 1'b0;
        best_key = '0;
        best_f = 0;
        case (act)
            ACT_RECORD:
            begin
                gstamp = gstamp + 32'd1;
                if (!trk[f])
                begin
                    trk[f] = 1'b1;
                    evm[f] = 1'b1;
                    acnt[f] = 0;
                    ev_total = ev_total + 7'd1;
                end
                for (int i = KMAX - 1; i > 0; i--)
                    stamps[f][i] = stamps[f][i - 1];
                stamps[f][0] = gstamp;
                acnt[f] = (acnt[f] + 1 > k) ? k : acnt[f] + 1;
            end
            ACT_SET:
            begin
                if (trk[f] && evm[f] != ev)
                begin
                    ev_total = ev ? ev_total + 7'd1 : ev_total - 7'd1;
                    evm[f] = ev;
                end
            end
            ACT_REMOVE:
            begin
                if (trk[f])
                begin
                    if (!evm[f])
                        r.status = ST_PINNED;
                    else
                    begin
                        trk[f] = 1'b0;
                        evm[f] = 1'b0;
                        acnt[f] = 0;
                        ev_total = ev_total - 7'd1;
                    end
                end
            end
            default:
            begin
                for (int g = 0; g < NFR; g++)
                begin
                    if (trk[g] && evm[g])
                    begin
                        c = (acnt[g] == 0) ? 1 : acnt[g];
                        if (c > KMAX)
                            c = KMAX;
                        young = c < k;
                        key = young ? stamps[g][c - 1] : stamps[g][k - 1];
                        if (!found || (young && !best_young) ||
                            (young == best_young && key < best_key))
                        begin
                            found = 1'b1;
                            best_young = young;
                            best_key = key;
                            best_f = g;
                        end
                    end
                end
                if (found)
                begin
                    trk[best_f] = 1'b0;
                    evm[best_f] = 1'b0;
                    acnt[best_f] = 0;
                    ev_total = ev_total - 7'd1;
                    r.victim = best_f[5:0];
                end
                else
                    r.status = ST_NO_VICTIM;
            end
        endcase
        r.ev_count = ev_total;
        return r;
    endfunction

    // Send one request; the prediction is queued at the accepting edge.
    // Valid stays up into the next call, which drops it only for an idle burst.
    task automatic send_request(action_t act, logic [5:0] f, logic ev);
        if (stall_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_axis_tdata  <= {7'b0, ev, f, act};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_q.push_back(predict_lru_k(act, f, ev));
        n_sent++;
        @(negedge clk);
    endtask

    // Hold until every expected result has come, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_depth(logic [2:0] k);
        drain_results();
        cfg_wdata <= k;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        depth_reg = k;
    endtask

    // Receiver: random stall bursts, check each result transfer
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[14:0];
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                n_checked++;
                if (got.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.victim !== exp_r.victim)
                begin
                    $error("victim_frame: expected %0d, got %0d", exp_r.victim, got.victim);
                    errors++;
                end
                if (got.ev_count !== exp_r.ev_count)
                begin
                    $error("evictable_count: expected %0d, got %0d",
                           exp_r.ev_count, got.ev_count);
                    errors++;
                end
            end
        end
    end

    // Corner cases: empty evict, untracked set/remove, pinned remove, young vs full history
    task automatic test_directed();
        send_request(ACT_EVICT, 6'd0, 1'b0);
        send_request(ACT_SET, 6'd5, 1'b1);
        send_request(ACT_REMOVE, 6'd5, 1'b0);
        send_request(ACT_RECORD, 6'd0, 1'b0);
        send_request(ACT_RECORD, 6'd63, 1'b1);
        send_request(ACT_RECORD, 6'd63, 1'b0);
        send_request(ACT_RECORD, 6'd42, 1'b0);
        send_request(ACT_SET, 6'd42, 1'b0);
        send_request(ACT_SET, 6'd42, 1'b0);
        send_request(ACT_REMOVE, 6'd42, 1'b1);
        send_request(ACT_EVICT, 6'd63, 1'b1);
        send_request(ACT_EVICT, 6'd21, 1'b0);
        send_request(ACT_EVICT, 6'd0, 1'b0);
        send_request(ACT_SET, 6'd42, 1'b1);
        send_request(ACT_REMOVE, 6'd42, 1'b0);
        send_request(ACT_EVICT, 6'd0, 1'b0);
    endtask

    // Records half of the time, on a small pool of frames so that histories fill up
    task automatic test_random(int n, int pool);
        action_t    act;
        logic [5:0] f;
        int         r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            act = (r < 50) ? ACT_RECORD : (r < 68) ? ACT_SET :
                  (r < 82) ? ACT_REMOVE : ACT_EVICT;
            f = (pool >= 64) ? 6'($urandom) : 6'($urandom_range(0, pool - 1));
            send_request(act, f, 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        errors = 0;
        cycles = 0;
        n_sent = 0;
        n_checked = 0;
        stall_en = 1'b1;
        depth_reg = 3'd2;
        gstamp = '0;
        ev_total = '0;
        for (int i = 0; i < NFR; i++)
        begin
            trk[i] = 1'b0;
            evm[i] = 1'b0;
            acnt[i] = 0;
            for (int j = 0; j < KMAX; j++)
                stamps[i][j] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        write_depth(3'd1);
        test_random(80, 12);
        write_depth(3'd4);
        test_random(100, 10);
        write_depth(3'd0);
        test_random(60, 64);
        write_depth(3'd7);
        test_random(80, 16);
        write_depth(3'd3);
        test_random(100, 8);
        // K lowered with long histories in place
        write_depth(3'd2);
        stall_en = 1'b0;
        test_random(120, 20);

        drain_results();
        $display("Checked %0d of %0d requests over history depths 0 to 7,",
                 n_checked, n_sent);
        $display("covering record, set evictable, remove and evict with stalls.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lrk_pkg.sv
design/lrk_ctrl.sv
design/lrk_datapath.sv
design/lru_k_frame_replacer.sv
design/lru_k_frame_replacer_checker.sv
tb/lru_k_frame_replacer_tb.sv
